// File: rtl/core/ciri_pkg.sv
// ============================================================================
// ciri_pkg - shared types and constants of the clipmap ring indexer
// Cell classes, register indexes, the cell word passed from the classifier
// to the triangle emitter and the triangle word delivered at the output.
// ============================================================================
package ciri_pkg;

  // Field widths fixed by the block's interface
  localparam int unsigned COORD_W = 8;
  localparam int unsigned SIDE_W  = 9;
  localparam int unsigned VN_W    = 10;
  localparam int unsigned MOFF_W  = 10;
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_MODE      = 2'd1;

  // Triangle topology of one cell
  typedef enum logic [2:0] {
    CLS_QUAD   = 3'd0,
    CLS_BOTTOM = 3'd1,
    CLS_TOP    = 3'd2,
    CLS_LEFT   = 3'd3,
    CLS_RIGHT  = 3'd4
  } cell_class_e;

  // Live configuration: snapped ring side and frame mode
  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              ring_mode;
  } ciri_cfg_t;

  // Classified cell, queued between classifier and emitter
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    cell_class_e        cls;
    logic [VN_W-1:0]    vn;
    logic [MOFF_W-1:0]  moff;
  } cell_word_t;

  // One emitted triangle
  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    cell_class_e      cls;
    logic             last;
  } tri_word_t;

endpackage

// File: rtl/core/ciri_fifo.sv
// ============================================================================
// ciri_fifo - small register queue
// Keeps words in arrival order; full and empty come straight from the
// occupancy register.
// ============================================================================
module ciri_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/ciri_front.sv
// ============================================================================
// ciri_front - cell classifier
// Checks a cell against the ring bounds and the central hole, picks its
// stitch class and the offset of its midpoint vertex in the midpoint runs.
// ============================================================================
module ciri_front
  import ciri_pkg::*;
(
  input  ciri_cfg_t          cfg_i,
  input  logic               accept_i,
  input  logic [COORD_W-1:0] cell_x_i,
  input  logic [COORD_W-1:0] cell_y_i,
  output logic               wr_o,
  output cell_word_t         word_o
);

  logic [SIDE_W-1:0] x, y, lo, hi, mid, lo_m1;
  logic              in_ring, in_x, in_y, in_hole;
  logic              is_bot, is_top, is_left, is_right;
  logic [SIDE_W-1:0] dx, dy;
  logic [MOFF_W-1:0] mid_w;

  // Ring geometry: side is a multiple of four, so 3N/4 is N - N/4
  assign x     = SIDE_W'(cell_x_i);
  assign y     = SIDE_W'(cell_y_i);
  assign lo    = cfg_i.side >> 2;
  assign hi    = cfg_i.side - lo;
  assign mid   = cfg_i.side >> 1;
  assign lo_m1 = lo - 1'b1;
  assign mid_w = MOFF_W'(mid);
  assign dx    = x - lo;
  assign dy    = y - lo;

  assign in_ring  = (x < cfg_i.side) && (y < cfg_i.side);
  assign in_x     = (x >= lo) && (x < hi);
  assign in_y     = (y >= lo) && (y < hi);
  assign in_hole  = cfg_i.ring_mode && in_x && in_y;
  assign is_bot   = cfg_i.ring_mode && in_x && (y == lo_m1);
  assign is_top   = cfg_i.ring_mode && in_x && (y == hi);
  assign is_left  = cfg_i.ring_mode && in_y && (x == lo_m1);
  assign is_right = cfg_i.ring_mode && in_y && (x == hi);

  // Classify and place the midpoint within its run
  always_comb begin
    word_o.x    = cell_x_i;
    word_o.y    = cell_y_i;
    word_o.vn   = VN_W'(cfg_i.side) + 1'b1;
    word_o.cls  = CLS_QUAD;
    word_o.moff = '0;
    if (is_bot) begin
      word_o.cls  = CLS_BOTTOM;
      word_o.moff = MOFF_W'(dx);
    end else if (is_top) begin
      word_o.cls  = CLS_TOP;
      word_o.moff = mid_w + MOFF_W'(dx);
    end else if (is_left) begin
      word_o.cls  = CLS_LEFT;
      word_o.moff = (mid_w << 1) + MOFF_W'(dy);
    end else if (is_right) begin
      word_o.cls  = CLS_RIGHT;
      word_o.moff = (mid_w << 1) + mid_w + MOFF_W'(dy);
    end
  end

  // Drop cells outside the ring and inside the hole
  assign wr_o = accept_i && in_ring && !in_hole;

endmodule

// File: rtl/core/ciri_back.sv
// ============================================================================
// ciri_back - triangle emitter
// Turns a classified cell into corner and midpoint indices, then issues
// its triangles one per cycle in winding order, stalling while tri_full_i is high.
// ============================================================================
module ciri_back
  import ciri_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ciri_cfg_t  cfg_i,
  input  cell_word_t cell_i,
  input  logic       cell_empty_i,
  output logic       cell_pop_o,
  output tri_word_t  tri_o,
  output logic       tri_wr_o,
  input  logic       tri_full_i
);

  logic [VN_W-1:0]  side_vn;
  logic [IDX_W-1:0] grid_q;

  // Index stage
  logic             a_valid_q;
  logic [IDX_W-1:0] a_bl_q, a_m_q;
  logic [VN_W-1:0]  a_vn_q;
  cell_class_e      a_cls_q;
  logic             a_load;

  // Emit stage
  logic             b_valid_q;
  logic [IDX_W-1:0] b_bl_q, b_br_q, b_tl_q, b_tr_q, b_m_q;
  cell_class_e      b_cls_q;
  logic [1:0]       b_idx_q;
  logic             b_load, emit, last;

  // Hold the grid vertex count for the current side
  assign side_vn = VN_W'(cfg_i.side) + 1'b1;
  always_ff @(posedge clk_i) begin
    grid_q <= IDX_W'(side_vn) * IDX_W'(side_vn);
  end

  // Handshake between stages
  assign last       = (b_cls_q == CLS_QUAD) ? (b_idx_q == 2'd1) : (b_idx_q == 2'd2);
  assign emit       = b_valid_q && !tri_full_i;
  assign b_load     = a_valid_q && (!b_valid_q || (emit && last));
  assign a_load     = !cell_empty_i && (!a_valid_q || b_load);
  assign cell_pop_o = a_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      b_idx_q   <= '0;
    end else begin
      if (a_load) begin
        a_valid_q <= 1'b1;
      end else if (b_load) begin
        a_valid_q <= 1'b0;
      end
      if (b_load) begin
        b_valid_q <= 1'b1;
        b_idx_q   <= '0;
      end else if (emit) begin
        if (last) begin
          b_valid_q <= 1'b0;
        end
        b_idx_q <= b_idx_q + 1'b1;
      end
    end
  end

  // Compute bottom-left corner and midpoint index
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_bl_q  <= IDX_W'(cell_i.y) * IDX_W'(cell_i.vn) + IDX_W'(cell_i.x);
      a_m_q   <= grid_q + IDX_W'(cell_i.moff);
      a_vn_q  <= cell_i.vn;
      a_cls_q <= cell_i.cls;
    end
  end

  // Expand the remaining corners
  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_bl_q  <= a_bl_q;
      b_br_q  <= a_bl_q + 1'b1;
      b_tl_q  <= a_bl_q + IDX_W'(a_vn_q);
      b_tr_q  <= a_bl_q + IDX_W'(a_vn_q) + 1'b1;
      b_m_q   <= a_m_q;
      b_cls_q <= a_cls_q;
    end
  end

  // Select the vertices of the current triangle
  always_comb begin
    tri_o.cls  = b_cls_q;
    tri_o.last = last;
    tri_o.a    = b_bl_q;
    tri_o.b    = b_br_q;
    tri_o.c    = b_tr_q;
    case (b_cls_q)
      CLS_QUAD: begin
        if (b_idx_q != 2'd0) begin
          tri_o.b = b_tr_q;
          tri_o.c = b_tl_q;
        end
      end
      CLS_BOTTOM: begin
        case (b_idx_q)
          2'd0: begin
            tri_o.a = b_bl_q; tri_o.b = b_m_q;  tri_o.c = b_tl_q;
          end
          2'd1: begin
            tri_o.a = b_bl_q; tri_o.b = b_br_q; tri_o.c = b_m_q;
          end
          default: begin
            tri_o.a = b_br_q; tri_o.b = b_tr_q; tri_o.c = b_m_q;
          end
        endcase
      end
      CLS_TOP: begin
        case (b_idx_q)
          2'd0: begin
            tri_o.a = b_tl_q; tri_o.b = b_bl_q; tri_o.c = b_m_q;
          end
          2'd1: begin
            tri_o.a = b_tl_q; tri_o.b = b_m_q;  tri_o.c = b_tr_q;
          end
          default: begin
            tri_o.a = b_m_q;  tri_o.b = b_br_q; tri_o.c = b_tr_q;
          end
        endcase
      end
      CLS_LEFT: begin
        case (b_idx_q)
          2'd0: begin
            tri_o.a = b_bl_q; tri_o.b = b_br_q; tri_o.c = b_m_q;
          end
          2'd1: begin
            tri_o.a = b_bl_q; tri_o.b = b_m_q;  tri_o.c = b_tl_q;
          end
          default: begin
            tri_o.a = b_tl_q; tri_o.b = b_m_q;  tri_o.c = b_tr_q;
          end
        endcase
      end
      CLS_RIGHT: begin
        case (b_idx_q)
          2'd0: begin
            tri_o.a = b_m_q;  tri_o.b = b_bl_q; tri_o.c = b_br_q;
          end
          2'd1: begin
            tri_o.a = b_m_q;  tri_o.b = b_br_q; tri_o.c = b_tr_q;
          end
          default: begin
            tri_o.a = b_m_q;  tri_o.b = b_tr_q; tri_o.c = b_tl_q;
          end
        endcase
      end
      default: begin
        tri_o.a = b_bl_q;
      end
    endcase
  end

  assign tri_wr_o = emit;

endmodule

// File: rtl/core/clipmap_ring_triangle_indexer_top.sv
// ============================================================================
// clipmap_ring_triangle_indexer_top - clipmap ring triangle index generator
// Accepts grid cells of an N-by-N clipmap ring and delivers each cell's
// triangles as vertex-index triples, with stitching around the hole.
// ============================================================================
// A cell is classified as it is taken; cells outside the
// ring or inside the hole leave no trace. The emitter issues one triangle
// per cycle while the result queue has room; a plain cell gives two
// triangles and a stitch cell three. The first triangle of a cell reaches
// the result ports through a 2-word cell queue, an index stage, the emitter
// and a 2-word result queue. The ring side is snapped down to a multiple of
// four, at least 4 and at most MAX_CELLS_PER_SIDE; indices wrap at 17 bits.
module clipmap_ring_triangle_indexer_top
  import ciri_pkg::*;
#(
  parameter int unsigned MAX_CELLS_PER_SIDE = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Cell input
  input  logic                 push,
  output logic                 full,
  input  logic [COORD_W-1:0]   cell_x_i,
  input  logic [COORD_W-1:0]   cell_y_i,
  // Triangle output
  output logic                 empty,
  input  logic                 pop,
  output logic [IDX_W-1:0]     vertex_a_o,
  output logic [IDX_W-1:0]     vertex_b_o,
  output logic [IDX_W-1:0]     vertex_c_o,
  output logic [2:0]           cell_class_o,
  output logic                 last_of_cell_o,
  // Register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIDE_W-1:0]    cfg_data_i
);

  localparam int unsigned CapRaw = MAX_CELLS_PER_SIDE & ~32'd3;
  localparam int unsigned Cap    = (CapRaw < 4) ? 4 : CapRaw;
  localparam int unsigned CmpW   = SIDE_W + 2;
  localparam int unsigned CellW  = $bits(cell_word_t);
  localparam int unsigned TriW   = $bits(tri_word_t);

  logic [SIDE_W-1:0] side_raw_q, side_snap;
  logic              mode_q;
  ciri_cfg_t         cfg;

  logic       cell_wr, cell_pop, cell_full, cell_empty;
  cell_word_t cell_in, cell_out;
  logic       tri_wr, tri_full;
  tri_word_t  tri_in, tri_out;

  // Capture register writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_raw_q <= SIDE_W'(64);
      mode_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CELLS_PER_SIDE: side_raw_q <= cfg_data_i;
        REG_RING_MODE:      mode_q     <= cfg_data_i[0];
        default:            ;
      endcase
    end
  end

  // Snap the side to a multiple of four within its limits
  always_comb begin
    side_snap = side_raw_q & ~SIDE_W'(3);
    if (side_snap < SIDE_W'(4)) begin
      side_snap = SIDE_W'(4);
    end
    if (CmpW'(side_snap) > CmpW'(Cap)) begin
      side_snap = SIDE_W'(Cap);
    end
  end

  assign cfg.side      = side_snap;
  assign cfg.ring_mode = mode_q;

  // Classify incoming cells
  ciri_front u_front (
    .cfg_i    (cfg),
    .accept_i (push && !full),
    .cell_x_i (cell_x_i),
    .cell_y_i (cell_y_i),
    .wr_o     (cell_wr),
    .word_o   (cell_in)
  );

  ciri_fifo #(
    .WIDTH (CellW),
    .DEPTH (2)
  ) u_cell_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cell_wr),
    .wdata_i (cell_in),
    .rd_i    (cell_pop),
    .rdata_o (cell_out),
    .full_o  (cell_full),
    .empty_o (cell_empty)
  );

  assign full = cell_full;

  // Emit triangles
  ciri_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cell_i       (cell_out),
    .cell_empty_i (cell_empty),
    .cell_pop_o   (cell_pop),
    .tri_o        (tri_in),
    .tri_wr_o     (tri_wr),
    .tri_full_i   (tri_full)
  );

  ciri_fifo #(
    .WIDTH (TriW),
    .DEPTH (2)
  ) u_tri_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tri_wr),
    .wdata_i (tri_in),
    .rd_i    (pop),
    .rdata_o (tri_out),
    .full_o  (tri_full),
    .empty_o (empty)
  );

  assign vertex_a_o     = tri_out.a;
  assign vertex_b_o     = tri_out.b;
  assign vertex_c_o     = tri_out.c;
  assign cell_class_o   = tri_out.cls;
  assign last_of_cell_o = tri_out.last;

endmodule
